@@ hw/rtl/wde_pkg.sv @@
// shared constants and types for the word dictionary encoder
`default_nettype none
package wde_pkg;
    localparam int WORDS   = 64;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int WLEN    = 127;
    localparam int LEN_W   = 8;
    localparam int ADDR_W  = 7;

    localparam logic KIND_LIT = 1'b0;
    localparam logic KIND_IDX = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        char_a;
        logic              cmp;
        logic [7:0]        char_b;
        logic              close;
        logic              commit;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  plen;
    } cell_ctrl_t;

    // one result beat
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       added;
        logic       last;
    } res_t;
endpackage
`default_nettype wire

@@ hw/rtl/wde_cell.sv @@
// one dictionary cell: stores a word and tracks a running match
`default_nettype none
module wde_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [wde_pkg::IDX_W-1:0] cell_idx,
    input  wire wde_pkg::cell_ctrl_t       ctrl,
    input  wire logic                      hit_in,
    input  wire logic [wde_pkg::IDX_W-1:0] idx_in,
    output logic                           hit_out,
    output logic [wde_pkg::IDX_W-1:0]      idx_out
);
    logic [7:0]                mem [wde_pkg::WLEN];
    logic [7:0]                rd_reg;
    logic                      valid_reg, valid_next;
    logic                      match_reg, match_next;
    logic [wde_pkg::LEN_W-1:0] len_reg, len_next;
    logic                      is_free;
    logic                      hit;

    assign is_free = ({1'b0, cell_idx} == ctrl.count);

    // letter store, written only while this cell is the next free one
    always_ff @(posedge aclk) begin
        if (ctrl.wr && is_free) begin
            mem[ctrl.addr] <= ctrl.char_a;
        end
        if (ctrl.rd) begin
            rd_reg <= mem[ctrl.addr];
        end
    end

    // match tracking and word commit
    always_comb begin
        valid_next = valid_reg;
        match_next = match_reg;
        len_next   = len_reg;
        if (ctrl.cmp) begin
            match_next = match_reg & (rd_reg == ctrl.char_b);
        end
        if (ctrl.close) begin
            match_next = 1'b1;
            if (ctrl.commit && is_free) begin
                valid_next = 1'b1;
                len_next   = ctrl.plen;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b1;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
        len_reg <= len_next;
    end

    // words are distinct, so at most one cell hits and an or-chain gives the index
    assign hit     = valid_reg && match_reg && (len_reg == ctrl.plen);
    assign hit_out = hit_in | hit;
    assign idx_out = idx_in | (hit ? cell_idx : '0);
endmodule
`default_nettype wire

@@ hw/rtl/word_dictionary_encoder_core.sv @@
// word dictionary encoder: sequencer, cell chain and result queue
// a letter goes via S_LET for the registered cell read, no beat unless dictionary full
// a delimiter ending a word passes S_CLOSE, then 2 beats; other chars 1 beat next cycle
// a flush gives only its word's index beat; s_ready is low in S_LET/S_CLOSE or 2+ queued
// reset: synchronous active-low aresetn empties the dictionary, pending word and queue
// the letter stores are not cleared; only committed entries are ever compared
`default_nettype none
module word_dictionary_encoder_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_flush,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_kind,
    output logic [7:0]      m_value,
    output logic            m_added,
    output logic            m_last
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LET   = 3'b010,
        S_CLOSE = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [7:0]                char_reg, char_next;
    logic                      flush_reg, flush_next;
    logic [wde_pkg::LEN_W-1:0] plen_reg, plen_next;
    logic                      inw_reg, inw_next;
    logic [wde_pkg::CNT_W-1:0] count_reg, count_next;
    wde_pkg::res_t             q_reg [3];
    wde_pkg::res_t             q_next [3];
    logic [1:0]                qcnt_reg, qcnt_next;

    wde_pkg::cell_ctrl_t       ctrl;
    logic                      hit_c [wde_pkg::WORDS+1];
    logic [wde_pkg::IDX_W-1:0] idx_c [wde_pkg::WORDS+1];

    logic                      accept, full, letter, pop;
    logic                      push0, push1;
    wde_pkg::res_t             r0, r1;
    logic [1:0]                base;

    assign full    = (count_reg == wde_pkg::CNT_W'(wde_pkg::WORDS));
    assign letter  = ((s_char_in >= 8'h61) && (s_char_in <= 8'h7a))
                  || ((s_char_in >= 8'h41) && (s_char_in <= 8'h5a));
    assign s_ready = (state_reg == S_IDLE) && (qcnt_reg <= 2'd1);
    assign accept  = s_valid && s_ready;
    assign m_valid = (qcnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign m_kind  = q_reg[0].kind;
    assign m_value = q_reg[0].value;
    assign m_added = q_reg[0].added;
    assign m_last  = q_reg[0].last;

    // cell chain
    assign hit_c[0] = 1'b0;
    assign idx_c[0] = '0;
    for (genvar e = 0; e < wde_pkg::WORDS; e++) begin : g_cell
        wde_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_idx(wde_pkg::IDX_W'(e)),
            .ctrl    (ctrl),
            .hit_in  (hit_c[e]),
            .idx_in  (idx_c[e]),
            .hit_out (hit_c[e+1]),
            .idx_out (idx_c[e+1])
        );
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        char_next  = char_reg;
        flush_next = flush_reg;
        plen_next  = plen_reg;
        inw_next   = inw_reg;
        count_next = count_reg;
        push0      = 1'b0;
        push1      = 1'b0;
        r0         = '{kind: wde_pkg::KIND_LIT, value: s_char_in, added: 1'b0, last: 1'b1};
        r1         = '{kind: wde_pkg::KIND_LIT, value: char_reg, added: 1'b0, last: 1'b1};
        ctrl        = '0;
        ctrl.addr   = plen_reg[wde_pkg::ADDR_W-1:0];
        ctrl.char_a = s_char_in;
        ctrl.char_b = char_reg;
        ctrl.count  = count_reg;
        ctrl.plen   = plen_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    char_next  = s_char_in;
                    flush_next = s_flush;
                    if (s_flush) begin
                        if (inw_reg && !full) begin
                            state_next = S_CLOSE;
                        end else begin
                            plen_next = '0;
                            inw_next  = 1'b0;
                        end
                    end else if (full) begin
                        push0 = 1'b1;
                    end else if (letter) begin
                        inw_next = 1'b1;
                        if (plen_reg < wde_pkg::LEN_W'(wde_pkg::WLEN)) begin
                            ctrl.rd    = 1'b1;
                            ctrl.wr    = 1'b1;
                            state_next = S_LET;
                        end
                    end else if (inw_reg) begin
                        state_next = S_CLOSE;
                    end else begin
                        push0 = 1'b1;
                    end
                end
            end
            S_LET: begin
                ctrl.cmp   = 1'b1;
                plen_next  = plen_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_CLOSE: begin
                ctrl.close = 1'b1;
                ctrl.commit = !hit_c[wde_pkg::WORDS];
                push0 = 1'b1;
                push1 = !flush_reg;
                r0.kind  = wde_pkg::KIND_IDX;
                r0.last  = flush_reg;
                if (hit_c[wde_pkg::WORDS]) begin
                    r0.value = 8'(idx_c[wde_pkg::WORDS]);
                    r0.added = 1'b0;
                end else begin
                    r0.value = 8'(count_reg);
                    r0.added = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                plen_next  = '0;
                inw_next   = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result queue: pop shifts down, pushes append
    always_comb begin
        q_next = q_reg;
        base   = qcnt_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            base      = qcnt_reg - 1'b1;
        end
        if (push0) begin
            q_next[base] = r0;
        end
        if (push1) begin
            q_next[base + 1'b1] = r1;
        end
        qcnt_next = base + {1'b0, push0} + {1'b0, push1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            plen_reg  <= '0;
            inw_reg   <= 1'b0;
            count_reg <= '0;
            qcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            plen_reg  <= plen_next;
            inw_reg   <= inw_next;
            count_reg <= count_next;
            qcnt_reg  <= qcnt_next;
        end
        char_reg  <= char_next;
        flush_reg <= flush_next;
        q_reg     <= q_next;
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= wde_pkg::CNT_W'(wde_pkg::WORDS)) else $error("word count overflow");
    a_queue_max: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg != 2'd3 || !s_ready) else $error("accept with full queue");
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLOSE |=> plen_reg == '0 && !inw_reg) else $error("word not cleared");
    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        plen_reg <= wde_pkg::LEN_W'(wde_pkg::WLEN)) else $error("pending length overflow");
`endif
endmodule
`default_nettype wire

@@ bench/tb_word_dictionary_encoder_core.sv @@
// testbench for the word dictionary encoder core with a scoreboard and random traffic
`timescale 1ns / 1ps
`default_nettype none
module tb_word_dictionary_encoder_core;

    // predicts the beats of the encoder and holds them until they arrive
    class dict_scoreboard;
        string words[$];
        string pending;
        bit    in_word;
        wde_pkg::res_t due[$];

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        // look the pending word up, store it when new, queue the index beat
        function void close_word(logic fin);
            int            idx;
            wde_pkg::res_t r;
            idx = words.size();
            for (int e = 0; e < words.size(); e++) begin
                if (words[e] == pending) begin
                    idx = e;
                    break;
                end
            end
            r.kind  = wde_pkg::KIND_IDX;
            r.value = idx[7:0];
            r.added = 1'b0;
            r.last  = fin;
            if (idx == words.size() && words.size() < wde_pkg::WORDS) begin
                words.push_back(pending);
                r.added = 1'b1;
            end
            due.push_back(r);
            pending = "";
            in_word = 1'b0;
        endfunction

        function void push_lit(logic [7:0] c);
            wde_pkg::res_t r;
            r.kind  = wde_pkg::KIND_LIT;
            r.value = c;
            r.added = 1'b0;
            r.last  = 1'b1;
            due.push_back(r);
        endfunction

        // note one accepted input beat
        function void note_beat(logic [7:0] c, logic f);
            if (f) begin
                if (in_word && words.size() < wde_pkg::WORDS) begin
                    close_word(1'b1);
                end else begin
                    pending = "";
                    in_word = 1'b0;
                end
            end else if (words.size() >= wde_pkg::WORDS) begin
                push_lit(c);
            end else if (is_alpha(c)) begin
                if (pending.len() < wde_pkg::WLEN) pending = {pending, string'(c)};
                in_word = 1'b1;
            end else if (in_word) begin
                close_word(1'b0);
                push_lit(c);
            end else begin
                push_lit(c);
            end
        endfunction

        // compare one result beat with the oldest prediction, empty string when fine
        function string check(wde_pkg::res_t got);
            wde_pkg::res_t want;
            if (due.size() == 0)
                return $sformatf("unexpected beat kind=%0d value=%0d", got.kind, got.value);
            want = due.pop_front();
            if (got !== want)
                return $sformatf("got kind=%0d value=%0d added=%0d last=%0d, want %0d %0d %0d %0d",
                                 got.kind, got.value, got.added, got.last,
                                 want.kind, want.value, want.added, want.last);
            return "";
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_flush;
    logic       m_valid;
    logic       m_ready;
    logic       m_kind;
    logic [7:0] m_value;
    logic       m_added;
    logic       m_last;

    dict_scoreboard sb;
    int  errors;
    int  accepted;
    bit  quiet;
    string pool[12];

    word_dictionary_encoder_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_char_in(s_char_in), .s_flush(s_flush),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_value(m_value),
        .m_added(m_added), .m_last(m_last)
    );

    // clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    task automatic report(string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // result side: check each beat, stall at random
    always @(posedge aclk) begin
        wde_pkg::res_t got;
        string         msg;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_kind, m_value, m_added, m_last};
                msg = sb.check(got);
                if (msg != "") report(msg);
            end
            m_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 17);
        end
    end

    // drive one input beat and wait for its handshake
    task automatic send(logic [7:0] c, logic f);
        while (!quiet && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            s_char_in <= 8'($urandom);
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        s_flush   <= f;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(c, f);
        accepted++;
    endtask

    function automatic logic [7:0] any_delim();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (sb.is_alpha(c));
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) ? "a" : "A") + c;
    endfunction

    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++) send(w[i], 1'b0);
    endtask

    // stimulus
    initial begin
        string w;
        int    pick;
        sb = new();
        errors = 0;
        accepted = 0;
        quiet = 1'b0;
        pool = '{"a", "Z", "the", "The", "abc", "zz", "Hello", "it", "is", "of", "q", "xyZ"};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_char_in = 8'h00;
        s_flush = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of the letter ranges, repeat lookup, flushes
        send("a", 1'b0); send("z", 1'b0); send(8'h20, 1'b0);
        send("A", 1'b0); send("Z", 1'b0); send(8'hFF, 1'b0);
        send("a", 1'b0); send("z", 1'b0); send(8'h00, 1'b0);
        send(8'h40, 1'b0); send(8'h5B, 1'b0); send(8'h60, 1'b0); send(8'h7B, 1'b0);
        send("Z", 1'b0); send(8'hA5, 1'b1);
        send(8'h5A, 1'b1);
        send("A", 1'b0); send("Z", 1'b0); send(8'h2C, 1'b0);
        send(8'h80, 1'b0); send(8'h7F, 1'b0);

        // random: mostly words with delimiters, some noise and flushes
        while (accepted < 400) begin
            quiet = (accepted > 150 && accepted < 230);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send(8'($urandom), 1'b0);
            end else if (pick < 18) begin
                send(8'($urandom), 1'b1);
            end else if (pick == 18) begin
                // overlong word, twice, so the truncated form matches
                w = "";
                for (int i = 0; i < 140; i++) w = {w, "k"};
                send_word(w); send(any_delim(), 1'b0);
                send_word({w, "kk"}); send(8'($urandom), 1'b1);
            end else begin
                if ($urandom_range(0, 99) < 55) begin
                    w = pool[$urandom_range(0, 11)];
                end else begin
                    w = "";
                    repeat ($urandom_range(1, 6)) w = {w, string'(any_letter())};
                end
                send_word(w);
                if ($urandom_range(0, 9) == 0) send(8'($urandom), 1'b1);
                else send(any_delim(), 1'b0);
            end
        end
        s_valid <= 1'b0;
        quiet = 1'b0;

        // drain
        while (sb.due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("[word_dictionary_encoder_core] OK");
        end else begin
            $display("[word_dictionary_encoder_core] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("[word_dictionary_encoder_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/wde_pkg.sv
hw/rtl/wde_cell.sv
hw/rtl/word_dictionary_encoder_core.sv
bench/tb_word_dictionary_encoder_core.sv
